>>> hw/rtl/min_coin_change_dp_top_defines.svh
// assertion macros for the minimum coin change block
// expects clk and rst_n in the scope that uses them, no other dependencies
`ifndef MIN_COIN_CHANGE_DP_TOP_DEFINES_SVH
`define MIN_COIN_CHANGE_DP_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MCC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define MCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/mcc_pkg.sv
// shared types and constants of the minimum coin change block
// no dependencies
package mcc_pkg;

    localparam int COIN_W     = 12;
    localparam int AMT_W      = 12;
    localparam int CNT_W      = 12;
    localparam int COIN_REGS  = 6;
    localparam int COIN_SLOTS = 8;
    localparam int COIN_IDX_W = 3;
    localparam int CFG_IDX_W  = 3;

    localparam int DEF_NUM_COINS  = 6;
    localparam int DEF_MAX_AMOUNT = 4095;

    // reset values of the denomination registers, entry 0 (700) is denomination one
    localparam logic [COIN_REGS-1:0][COIN_W-1:0] COIN_RESET = {
        12'd1, 12'd5, 12'd20, 12'd60, 12'd300, 12'd700
    };

    typedef logic [COIN_SLOTS-1:0][COIN_W-1:0] denom_vec_t;

    typedef struct packed {
        logic                  reach;
        logic [CNT_W-1:0]      count;
        logic [COIN_IDX_W-1:0] last;
    } tbl_entry_t;

    typedef struct packed {
        logic                  clear;
        logic                  inc;
        logic [COIN_IDX_W-1:0] inc_idx;
        logic                  start;
        logic                  special;
        logic                  special_reach;
        logic [CNT_W-1:0]      total;
    } tally_ctrl_t;

    typedef struct packed {
        logic busy;
    } tally_stat_t;

endpackage

>>> hw/rtl/mcc_req_if.sv
// request channel of the minimum coin change block
// depends on mcc_pkg
interface mcc_req_if
    import mcc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [AMT_W-1:0] target_amount;

    modport source (output valid, output target_amount, input ready);
    modport sink   (input valid, input target_amount, output ready);
endinterface

>>> hw/rtl/mcc_rsp_if.sv
// result channel of the minimum coin change block
// depends on mcc_pkg
interface mcc_rsp_if
    import mcc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [COIN_W-1:0] coin_value;
    logic [CNT_W-1:0]  coin_used_count;
    logic [CNT_W-1:0]  total_coins;
    logic              reachable;
    logic              last_result;

    modport source (output valid, output coin_value, output coin_used_count,
                    output total_coins, output reachable, output last_result,
                    input ready);
    modport sink   (input valid, input coin_value, input coin_used_count,
                    input total_coins, input reachable, input last_result,
                    output ready);
endinterface

>>> hw/rtl/mcc_tally_unit.sv
// per-denomination tallies, result scan and output register
// depends on mcc_pkg and mcc_rsp_if
module mcc_tally_unit
    import mcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tally_ctrl_t ctrl,
    input  denom_vec_t  denom,
    output tally_stat_t stat,
    mcc_rsp_if.source   rsp
);

    logic [COIN_SLOTS-1:0][CNT_W-1:0] tally_reg;
    logic                  busy_reg, busy_next;
    logic [COIN_IDX_W-1:0] e_reg, e_next;
    logic                  spec_reg;
    logic                  spec_reach_reg;
    logic [CNT_W-1:0]      total_reg;

    logic                  ov_reg, ov_next;
    logic [COIN_W-1:0]     value_reg;
    logic [CNT_W-1:0]      used_reg;
    logic [CNT_W-1:0]      tot_reg;
    logic                  reach_reg;
    logic                  last_reg;

    logic [COIN_SLOTS-1:0] nz;
    logic [COIN_SLOTS-1:0] upper;
    logic                  slot_free;
    logic                  load;
    logic [COIN_W-1:0]     ld_value;
    logic [CNT_W-1:0]      ld_used;
    logic [CNT_W-1:0]      ld_total;
    logic                  ld_reach;
    logic                  ld_last;

    always_comb
    begin
        for (int k = 0; k < COIN_SLOTS; k++)
        begin
            nz[k] = |tally_reg[k];
        end
    end

    // tallies above the scan position
    assign upper     = (nz >> e_reg) >> 1;
    assign slot_free = !ov_reg || rsp.ready;

    always_comb
    begin
        load      = 1'b0;
        busy_next = busy_reg;
        e_next    = e_reg;
        ld_value  = '0;
        ld_used   = '0;
        ld_total  = '0;
        ld_reach  = 1'b0;
        ld_last   = 1'b1;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            e_next    = '0;
        end
        else if (busy_reg)
        begin
            if (spec_reg)
            begin
                if (slot_free)
                begin
                    load      = 1'b1;
                    ld_reach  = spec_reach_reg;
                    busy_next = 1'b0;
                end
            end
            else if (!nz[e_reg])
            begin
                // skip unused denominations, stop after the top slot
                e_next = e_reg + 1'b1;
                if (e_reg == COIN_IDX_W'(COIN_SLOTS - 1))
                begin
                    busy_next = 1'b0;
                end
            end
            else if (slot_free)
            begin
                load     = 1'b1;
                ld_value = denom[e_reg];
                ld_used  = tally_reg[e_reg];
                ld_total = total_reg;
                ld_reach = 1'b1;
                ld_last  = (upper == '0);
                e_next   = e_reg + 1'b1;
                if (upper == '0)
                begin
                    busy_next = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        ov_next = ov_reg;
        if (load)
        begin
            ov_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tally_reg <= '0;
            busy_reg  <= 1'b0;
            e_reg     <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (ctrl.clear)
            begin
                tally_reg <= '0;
            end
            else if (ctrl.inc)
            begin
                tally_reg[ctrl.inc_idx] <= tally_reg[ctrl.inc_idx] + 1'b1;
            end
            busy_reg <= busy_next;
            e_reg    <= e_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            spec_reg       <= ctrl.special;
            spec_reach_reg <= ctrl.special_reach;
            total_reg      <= ctrl.total;
        end
        if (load)
        begin
            value_reg <= ld_value;
            used_reg  <= ld_used;
            tot_reg   <= ld_total;
            reach_reg <= ld_reach;
            last_reg  <= ld_last;
        end
    end

    assign stat.busy           = busy_reg;
    assign rsp.valid           = ov_reg;
    assign rsp.coin_value      = value_reg;
    assign rsp.coin_used_count = used_reg;
    assign rsp.total_coins     = tot_reg;
    assign rsp.reachable       = reach_reg;
    assign rsp.last_result     = last_reg;

endmodule

>>> hw/rtl/min_coin_change_dp_top.sv
// top level of the minimum coin change block: sequencer, table memory, config
// depends on mcc_pkg, mcc_req_if, mcc_rsp_if, mcc_tally_unit and the defines header
`include "min_coin_change_dp_top_defines.svh"

// usage
//   req: one request carries a target amount; ready is high only while the
//     block is idle, so one request is worked on at a time
//   rsp: one result per denomination used, lowest index first, last one
//     marked; a zero target gives one reachable result with total 0, an
//     unreachable target (or one above MAX_AMOUNT) gives one with reachable low
//   cfg: coin_value_1..6 at index 0..5, written only while idle by the user, which the block
//     does not enforce; a zero value disables that denomination, other indexes are ignored
// steps
//   fill: amounts 1..target in turn, each tried against every denomination through the
//     single table memory read port, the shared subtract unit and the compare stage
//   traceback: per coin a memory read, then tally and subtract
//   scan: each denomination slot in turn up to the last one used, waiting while a
//     result is held for a stalled receiver
// reset: denominations return to 700, 300, 60, 20, 5, 1, tallies clear; the
//   table needs no clearing since every request rewrites what it reads
// stall: a result waits in the output register, and the next request is
//   taken once the current one's last result is loaded
module min_coin_change_dp_top
    import mcc_pkg::*;
#(
    parameter int NUM_COINS  = DEF_NUM_COINS,
    parameter int MAX_AMOUNT = DEF_MAX_AMOUNT
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COIN_W-1:0]    cfg_data,
    mcc_req_if.sink              req,
    mcc_rsp_if.source            rsp
);

    localparam int AW    = $clog2(MAX_AMOUNT + 1);
    localparam int DEPTH = MAX_AMOUNT + 1;
    localparam int KW    = $clog2(NUM_COINS + 1);
    localparam logic [KW-1:0] K_LAST = KW'(NUM_COINS);

    // sequencer states
    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] S_IDLE       = 3'd0;
    localparam logic [ST_W-1:0] S_FILL       = 3'd1;
    localparam logic [ST_W-1:0] S_TR_ISSUE   = 3'd2;
    localparam logic [ST_W-1:0] S_TR_USE     = 3'd3;
    localparam logic [ST_W-1:0] S_EMIT_START = 3'd4;
    localparam logic [ST_W-1:0] S_EMIT_WAIT  = 3'd5;

    // configuration registers
    logic [COIN_REGS-1:0][COIN_W-1:0] coin_reg;
    denom_vec_t                       denom;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coin_reg <= COIN_RESET;
        end
        else
        begin
            for (int j = 0; j < COIN_REGS; j++)
            begin
                if (cfg_write_en && (cfg_index == CFG_IDX_W'(j)))
                begin
                    coin_reg[j] <= cfg_data;
                end
            end
        end
    end

    // slots past the register file or past NUM_COINS read as disabled
    for (genvar j = 0; j < COIN_SLOTS; j++)
    begin : g_denom
        if (j < NUM_COINS && j < COIN_REGS)
        begin : g_on
            assign denom[j] = coin_reg[j];
        end
        else
        begin : g_off
            assign denom[j] = '0;
        end
    end

    // sequencer registers
    logic [ST_W-1:0]       state_reg, state_next;
    logic [KW-1:0]         k_reg, k_next;
    logic [AMT_W-1:0]      p_reg, p_next;
    logic [AMT_W-1:0]      a_reg, a_next;
    logic [AMT_W-1:0]      target_reg, target_next;
    logic                  found_reg, found_next;
    logic [CNT_W-1:0]      best_reg, best_next;
    logic [COIN_IDX_W-1:0] best_idx_reg, best_idx_next;
    logic                  cand_vld_reg, cand_vld_next;
    logic [COIN_IDX_W-1:0] cand_idx_reg, cand_idx_next;
    logic [CNT_W-1:0]      total_reg, total_next;
    logic                  spec_reg, spec_next;
    logic                  spec_reach_reg, spec_reach_next;

    // table memory: reach bit, coin count and last coin per amount
    tbl_entry_t tbl_mem [DEPTH];
    tbl_entry_t rd_data_reg;
    logic       wr_en;
    logic [AW-1:0] wr_addr;
    tbl_entry_t wr_data;
    logic [AW-1:0] rd_addr;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tbl_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= tbl_mem[rd_addr];
    end

    // shared subtract unit: amount minus coin, for table address and traceback
    logic [AMT_W-1:0]      op_a;
    logic [COIN_IDX_W-1:0] op_idx;
    logic [COIN_W-1:0]     op_v;
    logic [AMT_W:0]        sub;
    logic                  fits;

    assign op_a   = (state_reg == S_FILL) ? p_reg : a_reg;
    assign op_idx = (state_reg == S_FILL) ? COIN_IDX_W'(k_reg) : rd_data_reg.last;
    assign op_v   = denom[op_idx];
    assign sub    = {1'b0, op_a} - {1'b0, op_v};
    assign fits   = !sub[AMT_W] && (op_v != '0);

    // compare stage, in the cycle after the read it uses
    logic [CNT_W-1:0]      cnt;
    logic                  take;
    logic                  found_n;
    logic [CNT_W-1:0]      best_n;
    logic [COIN_IDX_W-1:0] best_idx_n;

    assign cnt        = rd_data_reg.count + 1'b1;
    assign take       = cand_vld_reg && rd_data_reg.reach && (!found_reg || (cnt < best_reg));
    assign found_n    = found_reg | take;
    assign best_n     = take ? cnt : best_reg;
    assign best_idx_n = take ? cand_idx_reg : best_idx_reg;

    tally_ctrl_t tally_ctrl;
    tally_stat_t tally_stat;

    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        p_next          = p_reg;
        a_next          = a_reg;
        target_next     = target_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        best_idx_next   = best_idx_reg;
        cand_vld_next   = 1'b0;
        cand_idx_next   = cand_idx_reg;
        total_next      = total_reg;
        spec_next       = spec_reg;
        spec_reach_next = spec_reach_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;
        rd_addr         = AW'(sub[AMT_W-1:0]);
        tally_ctrl               = '0;
        tally_ctrl.total         = total_reg;
        tally_ctrl.special       = spec_reg;
        tally_ctrl.special_reach = spec_reach_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    tally_ctrl.clear = 1'b1;
                    target_next      = req.target_amount;
                    found_next       = 1'b0;
                    best_next        = '0;
                    best_idx_next    = '0;
                    k_next           = '0;
                    p_next           = AMT_W'(1);
                    total_next       = '0;
                    if (int'(req.target_amount) > MAX_AMOUNT)
                    begin
                        spec_next       = 1'b1;
                        spec_reach_next = 1'b0;
                        state_next      = S_EMIT_START;
                    end
                    else
                    begin
                        // amount zero is always reachable with no coins
                        wr_en         = 1'b1;
                        wr_addr       = '0;
                        wr_data.reach = 1'b1;
                        if (req.target_amount == '0)
                        begin
                            spec_next       = 1'b1;
                            spec_reach_next = 1'b1;
                            state_next      = S_EMIT_START;
                        end
                        else
                        begin
                            spec_next  = 1'b0;
                            state_next = S_FILL;
                        end
                    end
                end
            end
            S_FILL:
            begin
                if (k_reg != K_LAST)
                begin
                    cand_vld_next = fits;
                    cand_idx_next = COIN_IDX_W'(k_reg);
                    found_next    = found_n;
                    best_next     = best_n;
                    best_idx_next = best_idx_n;
                    k_next        = k_reg + 1'b1;
                end
                else
                begin
                    wr_en         = 1'b1;
                    wr_addr       = AW'(p_reg);
                    wr_data.reach = found_n;
                    wr_data.count = found_n ? best_n : '0;
                    wr_data.last  = best_idx_n;
                    found_next    = 1'b0;
                    best_next     = '0;
                    best_idx_next = '0;
                    k_next        = '0;
                    if (p_reg == target_reg)
                    begin
                        if (found_n)
                        begin
                            total_next = best_n;
                            a_next     = target_reg;
                            state_next = S_TR_ISSUE;
                        end
                        else
                        begin
                            total_next      = '0;
                            spec_next       = 1'b1;
                            spec_reach_next = 1'b0;
                            state_next      = S_EMIT_START;
                        end
                    end
                    else
                    begin
                        p_next = p_reg + 1'b1;
                    end
                end
            end
            S_TR_ISSUE:
            begin
                rd_addr    = AW'(a_reg);
                state_next = S_TR_USE;
            end
            S_TR_USE:
            begin
                if (!fits)
                begin
                    state_next = S_EMIT_START;
                end
                else
                begin
                    tally_ctrl.inc     = 1'b1;
                    tally_ctrl.inc_idx = rd_data_reg.last;
                    a_next             = sub[AMT_W-1:0];
                    if (sub[AMT_W-1:0] == '0)
                    begin
                        state_next = S_EMIT_START;
                    end
                    else
                    begin
                        state_next = S_TR_ISSUE;
                    end
                end
            end
            S_EMIT_START:
            begin
                tally_ctrl.start = 1'b1;
                state_next       = S_EMIT_WAIT;
            end
            S_EMIT_WAIT:
            begin
                if (!tally_stat.busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req.ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            k_reg        <= '0;
            found_reg    <= 1'b0;
            cand_vld_reg <= 1'b0;
            spec_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            found_reg    <= found_next;
            cand_vld_reg <= cand_vld_next;
            spec_reg     <= spec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg          <= p_next;
        a_reg          <= a_next;
        target_reg     <= target_next;
        best_reg       <= best_next;
        best_idx_reg   <= best_idx_next;
        cand_idx_reg   <= cand_idx_next;
        total_reg      <= total_next;
        spec_reach_reg <= spec_reach_next;
    end

    mcc_tally_unit u_tally (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (tally_ctrl),
        .denom (denom),
        .stat  (tally_stat),
        .rsp   (rsp)
    );

    // an idle sequencer never leaves a result scan running
    `MCC_ASSERT_IMPL(a_idle_scan_done, state_reg == S_IDLE, !tally_stat.busy,
        "sequencer idle while result scan still busy")
    // an in-range nonzero target always starts the table fill
    `MCC_ASSERT_NEXT(a_fill_start,
        req.valid && req.ready && (req.target_amount != '0) &&
        (int'(req.target_amount) <= MAX_AMOUNT),
        state_reg == S_FILL, "nonzero target did not start the fill")
    // coin step counter stays within the denominations plus the write step
    `MCC_ASSERT_IMPL(a_k_range, state_reg == S_FILL, k_reg <= K_LAST,
        "coin step counter out of range")
    // traceback only counts enabled denominations
    `MCC_ASSERT_IMPL(a_tally_enabled, tally_ctrl.inc, denom[tally_ctrl.inc_idx] != '0,
        "tally of a disabled denomination")

endmodule
